// ===== src/assert_macros.svh =====
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on aclk, quiet while aresetn is low
`define WFED_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked on aclk, checked at every edge
`define WFED_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/wfed_pkg.sv =====
package wfed_pkg;

    localparam int MAX_RADIUS_DEF = 8;
    localparam int RADIUS_W       = 4;
    localparam int PRICE_W        = 32;
    localparam int TIME_W         = 64;
    localparam int INDEX_W        = 32;
    localparam int S_TDATA_W      = 2 * PRICE_W + TIME_W;
    localparam int M_TDATA_W      = INDEX_W + TIME_W + PRICE_W;

    localparam logic [RADIUS_W-1:0]      RADIUS_RESET = 4'd2;
    localparam logic signed [PRICE_W-1:0] ZERO_PRICE  = '0;
    localparam logic [INDEX_W-1:0]        INDEX_SAT   = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_HIGH,
        ST_LOW
    } wfed_state_t;

    typedef enum logic {
        KIND_HIGH = 1'b0,
        KIND_LOW  = 1'b1
    } wfed_kind_t;

    typedef struct packed {
        logic load;
        logic capture;
        logic emit_low;
        logic emit_last;
    } wfed_cmd_t;

    typedef struct packed {
        logic found_high;
        logic found_low;
    } wfed_status_t;

endpackage

// ===== src/wfed_ctrl.sv =====
module wfed_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  wfed_pkg::wfed_status_t status,
    output wfed_pkg::wfed_cmd_t    cmd
);
    import wfed_pkg::*;

    wfed_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.found_high) begin
                    state_next = ST_HIGH;
                end else if (status.found_low) begin
                    state_next = ST_LOW;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HIGH: begin
                if (m_tready) begin
                    state_next = status.found_low ? ST_LOW : ST_IDLE;
                end
            end
            ST_LOW: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        cmd.load      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.emit_low  = 1'b0;
        cmd.emit_last = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EVAL: begin
                cmd.capture = 1'b1;
            end
            ST_HIGH: begin
                m_tvalid      = 1'b1;
                cmd.emit_last = !status.found_low;
            end
            ST_LOW: begin
                m_tvalid      = 1'b1;
                cmd.emit_low  = 1'b1;
                cmd.emit_last = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/wfed_datapath.sv =====
module wfed_datapath #(
    parameter int MAX_RADIUS = wfed_pkg::MAX_RADIUS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [wfed_pkg::RADIUS_W-1:0]         cfg_wr_data,
    input  wfed_pkg::wfed_cmd_t                   cmd,
    output wfed_pkg::wfed_status_t                status,
    input  logic signed [wfed_pkg::PRICE_W-1:0]   bar_high,
    input  logic signed [wfed_pkg::PRICE_W-1:0]   bar_low,
    input  logic [wfed_pkg::TIME_W-1:0]           bar_time,
    input  logic                                  series_start,
    output logic                                  extremum_kind,
    output logic [wfed_pkg::INDEX_W-1:0]          bar_index,
    output logic [wfed_pkg::TIME_W-1:0]           extremum_time,
    output logic signed [wfed_pkg::PRICE_W-1:0]   extremum_price,
    output logic                                  last_result
);
    import wfed_pkg::*;

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int ERAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int WIN_IDX_W = $clog2(WIN_DEPTH);

    logic [RADIUS_W-1:0]       radius_reg, radius_next;
    logic [INDEX_W-1:0]        bars_seen_reg, bars_seen_next;
    logic signed [PRICE_W-1:0] high_win_reg [WIN_DEPTH];
    logic signed [PRICE_W-1:0] low_win_reg  [WIN_DEPTH];
    logic [TIME_W-1:0]         time_win_reg [WIN_DEPTH];

    logic [INDEX_W-1:0]        hold_index_reg;
    logic [TIME_W-1:0]         hold_time_reg;
    logic signed [PRICE_W-1:0] hold_high_reg;
    logic signed [PRICE_W-1:0] hold_low_reg;

    logic [ERAD_W-1:0]         eff_rad;
    logic [ERAD_W:0]           span;
    logic [WIN_IDX_W-1:0]      centre_idx;
    logic signed [PRICE_W-1:0] centre_high;
    logic signed [PRICE_W-1:0] centre_low;
    logic [WIN_DEPTH-1:0]      high_ok;
    logic [WIN_DEPTH-1:0]      low_ok;
    logic                      count_ok;
    logic                      centre_pos;
    logic [INDEX_W-1:0]        centre_index;

    assign radius_next = cfg_wr_en ? cfg_wr_data : radius_reg;

    always_comb begin
        bars_seen_next = bars_seen_reg;
        if (cmd.load) begin
            if (series_start) begin
                bars_seen_next = INDEX_W'(1);
            end else if (bars_seen_reg != INDEX_SAT) begin
                bars_seen_next = bars_seen_reg + INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= RADIUS_RESET;
            bars_seen_reg <= '0;
        end else begin
            radius_reg    <= radius_next;
            bars_seen_reg <= bars_seen_next;
        end
    end

    // bar window, entry 0 newest
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            high_win_reg[0] <= bar_high;
            low_win_reg[0]  <= bar_low;
            time_win_reg[0] <= bar_time;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                high_win_reg[i] <= high_win_reg[i-1];
                low_win_reg[i]  <= low_win_reg[i-1];
                time_win_reg[i] <= time_win_reg[i-1];
            end
        end
    end

    always_comb begin
        if (radius_reg == '0) begin
            eff_rad = ERAD_W'(1);
        end else if (32'(radius_reg) > 32'(MAX_RADIUS)) begin
            eff_rad = ERAD_W'(MAX_RADIUS);
        end else begin
            eff_rad = ERAD_W'(radius_reg);
        end
    end

    assign span        = {eff_rad, 1'b0};
    assign centre_idx  = WIN_IDX_W'(eff_rad);
    assign centre_high = high_win_reg[centre_idx];
    assign centre_low  = low_win_reg[centre_idx];

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (((ERAD_W+1)'(i) <= span) && ((ERAD_W+1)'(i) != {1'b0, eff_rad})) begin
                high_ok[i] = high_win_reg[i] < centre_high;
                low_ok[i]  = low_win_reg[i] > centre_low;
            end else begin
                high_ok[i] = 1'b1;
                low_ok[i]  = 1'b1;
            end
        end
    end

    assign count_ok   = bars_seen_reg >= (INDEX_W'(span) + INDEX_W'(1));
    assign centre_pos = (centre_high > ZERO_PRICE) && (centre_low > ZERO_PRICE);

    assign status.found_high = count_ok && centre_pos && (&high_ok);
    assign status.found_low  = count_ok && centre_pos && (&low_ok);

    assign centre_index = (bars_seen_reg == INDEX_SAT) ? INDEX_SAT :
                          bars_seen_reg - INDEX_W'(eff_rad) - INDEX_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            hold_index_reg <= centre_index;
            hold_time_reg  <= time_win_reg[centre_idx];
            hold_high_reg  <= centre_high;
            hold_low_reg   <= centre_low;
        end
    end

    assign extremum_kind  = cmd.emit_low ? KIND_LOW : KIND_HIGH;
    assign bar_index      = hold_index_reg;
    assign extremum_time  = hold_time_reg;
    assign extremum_price = cmd.emit_low ? hold_low_reg : hold_high_reg;
    assign last_result    = cmd.emit_last;

endmodule

// ===== src/window_fractal_extremum_detector.sv =====
// Williams fractal detector. Each accepted bar enters a window of the last 2*MAX_RADIUS+1 bars;
// once 2r+1 bars of the series have arrived, the bar r places back is tested against its r
// neighbours on each side and up to two results follow, high fractal before low fractal, the
// final one of a bar marked by m_tlast. One bar is in flight at a time: the bar is accepted, then
// the parallel window compare runs, and each result is held until m_tready takes it. s_tready is
// high only while the controller is idle. Write cfg_wr_data to set the radius (reset 2, zero
// acts as 1, values above MAX_RADIUS act as MAX_RADIUS); it applies from the next bar.
module window_fractal_extremum_detector #(
    parameter int MAX_RADIUS = wfed_pkg::MAX_RADIUS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [wfed_pkg::RADIUS_W-1:0]      cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bar_high, bar_low, bar_time
    input  logic [wfed_pkg::S_TDATA_W-1:0]     s_tdata,
    // series_start
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bar_index, extremum_time, extremum_price
    output logic [wfed_pkg::M_TDATA_W-1:0]     m_tdata,
    // extremum_kind
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);
    import wfed_pkg::*;

    wfed_cmd_t                 cmd;
    wfed_status_t              status;
    logic signed [PRICE_W-1:0] bar_high;
    logic signed [PRICE_W-1:0] bar_low;
    logic [TIME_W-1:0]         bar_time;
    logic                      extremum_kind;
    logic [INDEX_W-1:0]        bar_index;
    logic [TIME_W-1:0]         extremum_time;
    logic signed [PRICE_W-1:0] extremum_price;

    assign bar_high = s_tdata[PRICE_W-1:0];
    assign bar_low  = s_tdata[2*PRICE_W-1:PRICE_W];
    assign bar_time = s_tdata[S_TDATA_W-1:2*PRICE_W];

    wfed_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wfed_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .status         (status),
        .bar_high       (bar_high),
        .bar_low        (bar_low),
        .bar_time       (bar_time),
        .series_start   (s_tuser[0]),
        .extremum_kind  (extremum_kind),
        .bar_index      (bar_index),
        .extremum_time  (extremum_time),
        .extremum_price (extremum_price),
        .last_result    (m_tlast)
    );

    assign m_tdata    = {extremum_price, extremum_time, bar_index};
    assign m_tuser[0] = extremum_kind;

endmodule

// ===== src/wfed_checker.sv =====
`include "assert_macros.svh"

module wfed_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wfed_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser,
    input logic                           m_tlast
);

    `WFED_ASSERT_CLK(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    `WFED_ASSERT_RST(a_one_at_a_time, s_tready |-> !m_tvalid, "input open while a result waits")

    `WFED_ASSERT_RST(a_eval_after_accept, (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid), "no evaluation cycle after accept")

    `WFED_ASSERT_RST(a_low_follows_high, (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser[0] && m_tlast), "first of two results not followed by final low item")

    `WFED_ASSERT_RST(a_stall_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result changed")

endmodule

bind window_fractal_extremum_detector wfed_checker u_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wfed_pkg::*;

    localparam int WIN = 2 * MAX_RADIUS_DEF + 1;

    localparam int STYLE_LEVELS = 0;
    localparam int STYLE_FULL   = 1;
    localparam int STYLE_WALK   = 2;

    typedef struct packed {
        logic                       start;
        logic [TIME_W-1:0]          stamp;
        logic signed [PRICE_W-1:0]  low;
        logic signed [PRICE_W-1:0]  high;
    } bar_t;

    typedef struct packed {
        wfed_kind_t                 kind;
        logic [INDEX_W-1:0]         index;
        logic [TIME_W-1:0]          stamp;
        logic signed [PRICE_W-1:0]  price;
        logic                       last;
    } fractal_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [RADIUS_W-1:0]    cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic [0:0]             s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;

    window_fractal_extremum_detector dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #10 aclk = ~aclk;

    // predicted block state
    logic signed [PRICE_W-1:0] high_win [WIN];
    logic signed [PRICE_W-1:0] low_win  [WIN];
    logic [TIME_W-1:0]         stamp_win[WIN];
    logic [INDEX_W-1:0]        seen_cnt  = '0;
    logic [RADIUS_W-1:0]       radius_q  = RADIUS_RESET;

    fractal_t    pending_fractals[$];
    bit          gaps_on          = 1'b1;
    int          ready_hold       = 0;
    int          bars_sent        = 0;
    int          series_sent      = 0;
    int          fractals_checked = 0;
    int          mismatch_count   = 0;
    int          radius_writes    = 0;
    int          walk_price       = 32'h0010_0000;
    logic [63:0] clock_stamp      = '0;

    initial begin
        for (int i = 0; i < WIN; i++) begin
            high_win[i]  = '0;
            low_win[i]   = '0;
            stamp_win[i] = '0;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!gaps_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 20);
    endfunction

    function automatic logic signed [PRICE_W-1:0] q16(input int units);
        return units <<< 16;
    endfunction

    function automatic bar_t bar_of(input logic signed [PRICE_W-1:0] high,
                                    input logic signed [PRICE_W-1:0] low,
                                    input logic [TIME_W-1:0] stamp, input logic start);
        bar_t b;
        b.high  = high;
        b.low   = low;
        b.stamp = stamp;
        b.start = start;
        return b;
    endfunction

    function automatic bar_t random_bar(input int style, input logic start);
        bar_t b;
        case (style)
            STYLE_LEVELS: begin
                b.high = q16($urandom_range(1, 8));
                b.low  = q16($urandom_range(1, 8));
            end
            STYLE_FULL: begin
                b.high = $urandom;
                b.low  = $urandom;
            end
            default: begin
                walk_price = walk_price + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                if (walk_price < 32'h0002_0000) begin
                    walk_price = 32'h0002_0000;
                end
                b.high = walk_price + $urandom_range(0, 32'h0000_8000);
                b.low  = walk_price - $urandom_range(0, 32'h0000_8000);
            end
        endcase
        // occasional non-positive price
        if ($urandom_range(0, 24) == 0) begin
            b.low = -$urandom_range(0, 1000);
        end else if ($urandom_range(0, 24) == 0) begin
            b.high = -$urandom_range(0, 1000);
        end
        if ($urandom_range(0, 9) == 0) begin
            b.stamp = {$urandom, $urandom};
        end else begin
            clock_stamp = clock_stamp + $urandom_range(1, 100);
            b.stamp = clock_stamp;
        end
        b.start = start;
        return b;
    endfunction

    task automatic predict_fractals(input bar_t b);
        int                        r;
        logic signed [PRICE_W-1:0] ch, cl;
        logic                      up, down;
        logic [INDEX_W-1:0]        idx;
        fractal_t                  f;
        if (b.start) begin
            for (int i = 0; i < WIN; i++) begin
                high_win[i]  = '0;
                low_win[i]   = '0;
                stamp_win[i] = '0;
            end
            seen_cnt = '0;
        end
        for (int i = WIN - 1; i > 0; i--) begin
            high_win[i]  = high_win[i-1];
            low_win[i]   = low_win[i-1];
            stamp_win[i] = stamp_win[i-1];
        end
        high_win[0]  = b.high;
        low_win[0]   = b.low;
        stamp_win[0] = b.stamp;
        if (seen_cnt != INDEX_SAT) begin
            seen_cnt++;
        end
        r = int'(radius_q);
        if (r < 1) begin
            r = 1;
        end
        if (r > MAX_RADIUS_DEF) begin
            r = MAX_RADIUS_DEF;
        end
        if (seen_cnt < 2 * r + 1) begin
            return;
        end
        ch = high_win[r];
        cl = low_win[r];
        if (ch <= ZERO_PRICE || cl <= ZERO_PRICE) begin
            return;
        end
        up   = 1'b1;
        down = 1'b1;
        for (int i = 0; i <= 2 * r; i++) begin
            if (i != r) begin
                if (high_win[i] >= ch) begin
                    up = 1'b0;
                end
                if (low_win[i] <= cl) begin
                    down = 1'b0;
                end
            end
        end
        idx = (seen_cnt == INDEX_SAT) ? INDEX_SAT : seen_cnt - 1 - r;
        f.index = idx;
        f.stamp = stamp_win[r];
        if (up) begin
            f.kind  = KIND_HIGH;
            f.price = ch;
            f.last  = !down;
            pending_fractals.insert(pending_fractals.size(), f);
        end
        if (down) begin
            f.kind  = KIND_LOW;
            f.price = cl;
            f.last  = 1'b1;
            pending_fractals.insert(pending_fractals.size(), f);
        end
    endtask

    task automatic send_bar(input bar_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.stamp, b.low, b.high};
        s_tuser  <= b.start;
        do @(posedge aclk); while (!s_tready);
        predict_fractals(b);
        bars_sent++;
    endtask

    task automatic send_series(input int length, input int style);
        logic start;
        series_sent++;
        for (int i = 0; i < length; i++) begin
            // mostly clean series, now and then a missing or stray start
            start = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 199) == 0);
            send_bar(random_bar(style, start));
        end
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_fractals.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        radius_q = value;
        radius_writes++;
    endtask

    function automatic int clamp_radius(input int value);
        return (value < 1) ? 1 : (value > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : value);
    endfunction

    // radius 2 from reset
    task automatic test_directed();
        // window filled straight after reset: wide centre bar, both kinds
        send_bar(bar_of(q16(10), q16(5), 64'd0, 1'b0));
        send_bar(bar_of(q16(11), q16(4), 64'd1, 1'b0));
        send_bar(bar_of(q16(20), q16(1), 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        send_bar(bar_of(q16(12), q16(3), 64'd3, 1'b0));
        send_bar(bar_of(q16(11), q16(2), 64'd4, 1'b0));
        // price extremes, high fractal only
        send_bar(bar_of(32'sh8000_0000, 32'sh8000_0000, 64'd10, 1'b1));
        send_bar(bar_of(32'sh0000_0001, 32'sh7FFF_FFFF, 64'd11, 1'b0));
        send_bar(bar_of(32'sh7FFF_FFFF, 32'sh0000_0001, 64'h8000_0000_0000_0000, 1'b0));
        send_bar(bar_of(32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 64'd13, 1'b0));
        send_bar(bar_of(32'sh8000_0000, 32'sh0000_0002, 64'd14, 1'b0));
        // tied high, low fractal only
        send_bar(bar_of(q16(5), q16(3), 64'd20, 1'b1));
        send_bar(bar_of(q16(6), q16(3), 64'd21, 1'b0));
        send_bar(bar_of(q16(9), q16(2), 64'd22, 1'b0));
        send_bar(bar_of(q16(9), q16(4), 64'd23, 1'b0));
        send_bar(bar_of(q16(4), q16(5), 64'd24, 1'b0));
        // zero centre low
        send_bar(bar_of(q16(1), q16(5), 64'd30, 1'b1));
        send_bar(bar_of(q16(2), q16(6), 64'd31, 1'b0));
        send_bar(bar_of(q16(50), 32'sd0, 64'd32, 1'b0));
        send_bar(bar_of(q16(3), q16(7), 64'd33, 1'b0));
        send_bar(bar_of(q16(4), q16(8), 64'd34, 1'b0));
        // negative centre high, but the series ends one bar short of a full window
        send_bar(bar_of(q16(-9), q16(5), 64'd40, 1'b1));
        send_bar(bar_of(q16(-8), q16(6), 64'd41, 1'b0));
        send_bar(bar_of(q16(-1), q16(1), 64'd42, 1'b0));
        send_bar(bar_of(q16(-7), q16(7), 64'd43, 1'b0));
        // short series
        send_bar(bar_of(q16(3), q16(1), 64'd50, 1'b1));
        send_bar(bar_of(q16(9), q16(1), 64'd51, 1'b1));
    endtask

    task automatic test_radius_sweep();
        int r;
        for (int v = 0; v < 16; v++) begin
            write_radius(RADIUS_W'(v));
            r = clamp_radius(v);
            send_series(2 * r + 1 + $urandom_range(4, 20), $urandom_range(STYLE_LEVELS, STYLE_WALK));
        end
    endtask

    task automatic test_random_series();
        int first, r;
        repeat (10) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            write_radius(RADIUS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(1, 4)));
            r = clamp_radius(int'(radius_q));
            first = bars_sent;
            while (bars_sent - first < 55) begin
                send_series($urandom_range(1, 4 * (2 * r + 1)),
                            ($urandom_range(0, 4) == 0) ? STYLE_FULL : $urandom_range(0, 1) * 2);
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        write_radius(RADIUS_W'(1));
        send_series(100, STYLE_LEVELS);
        write_radius(RADIUS_W'(MAX_RADIUS_DEF));
        send_series(60, STYLE_WALK);
        gaps_on = 1'b1;
    endtask

    always @(posedge aclk) begin : ready_gen
        int g;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else begin
            g = pick_gap();
            m_tready   <= (g == 0);
            ready_hold <= (g > 0) ? g - 1 : 0;
        end
    end

    function automatic string fractal_text(input fractal_t f);
        return $sformatf("kind %0d index %0d time %h price %h last %b",
                         f.kind, f.index, f.stamp, f.price, f.last);
    endfunction

    always @(posedge aclk) begin : fractal_check
        fractal_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = wfed_kind_t'(m_tuser[0]);
            got.index = m_tdata[INDEX_W-1:0];
            got.stamp = m_tdata[INDEX_W+TIME_W-1:INDEX_W];
            got.price = m_tdata[M_TDATA_W-1:INDEX_W+TIME_W];
            got.last  = m_tlast;
            if (pending_fractals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: %s", fractal_text(got));
                end
            end else begin
                want = pending_fractals.pop_front();
                fractals_checked++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected %s", fractal_text(want));
                        $display("          actual   %s", fractal_text(got));
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_fractals.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        int waited;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_radius_sweep();
        test_random_series();
        test_back_to_back();
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_fractals.size() > 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (pending_fractals.size() > 0) begin
            $display("%0d expected results never arrived", pending_fractals.size());
            mismatch_count += pending_fractals.size();
        end
        $display("%0d bars in %0d series over %0d radius writes, %0d fractals checked",
                 bars_sent, series_sent, radius_writes, fractals_checked);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
